// ===== hw/rtl/pau_pkg.sv =====
// Shared types, widths and polynomial coefficients for the polynomial activation unit.
// No dependencies; every other file of the unit imports this package.
`timescale 1ns / 1ps

package pau_pkg;

  localparam int unsigned X_W       = 32;  // Q8.24 sample and result
  localparam int unsigned Y_W       = 32;
  localparam int unsigned P_W       = 48;  // saturated products, +-(2^47-1)
  localparam int unsigned C_W       = 49;  // Q.48 coefficients with sign
  localparam int unsigned S_W       = 51;  // sum of five terms
  localparam int unsigned CHUNK_W   = 32;  // partial product operand width
  localparam int unsigned MUL_LAT   = 4;   // stages of one multiply unit
  localparam int unsigned PIPE_LAT  = 5 * MUL_LAT + 1;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned CF_FRAC_W = 48;
  localparam int unsigned ORD_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ORD_W-1:0] ORDER_3 = 3'd3;
  localparam logic [ORD_W-1:0] ORDER_5 = 3'd5;
  localparam logic [ORD_W-1:0] ORDER_7 = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGMOID_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TANH_ORDER    = 2'd1;

  localparam logic [P_W-1:0] P_LIM = {1'b0, {(P_W-1){1'b1}}};

  typedef enum logic {
    KIND_SIGMOID = 1'b0,
    KIND_TANH    = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ROW_SIG3,
    ROW_SIG5,
    ROW_SIG7,
    ROW_TANH5,
    ROW_TANH7
  } row_e;

  typedef struct packed {
    logic last;
    row_e row;
  } meta_t;

  typedef struct packed {
    meta_t                  meta;
    logic signed [X_W-1:0]  x;
    logic signed [P_W-1:0]  p3;
    logic signed [P_W-1:0]  p5;
    logic signed [P_W-1:0]  p7;
  } pow_beat_t;

  typedef struct packed {
    logic signed [C_W-1:0] c1;
    logic signed [C_W-1:0] c3;
    logic signed [C_W-1:0] c5;
    logic signed [C_W-1:0] c7;
  } coef_t;

  // Powers of ten for the decimal coefficient mantissas.
  localparam logic [127:0] POW10_1  = 128'd10;
  localparam logic [127:0] POW10_7  = 128'd10000000;
  localparam logic [127:0] POW10_16 = 128'd10000000000000000;
  localparam logic [127:0] POW10_17 = 128'd100000000000000000;
  localparam logic [127:0] POW10_18 = 128'd1000000000000000000;
  localparam logic [127:0] POW10_19 = 128'd10000000000000000000;
  localparam logic [127:0] POW10_20 = 128'd100000000000000000000;
  localparam logic [127:0] POW10_22 = 128'd10000000000000000000000;

  // Magnitudes rounded half up to Q.48: floor(m * 2^49 / 10^e), plus one, halved.
  localparam logic [127:0] SIG_C0_M  = ((128'd5 << 49) / POW10_1 + 128'd1) >> 1;

  localparam logic [127:0] S3_C1_M   = ((128'd1424534 << 49) / POW10_7 + 128'd1) >> 1;
  localparam logic [127:0] S3_C3_M   = ((128'd13186 << 49) / POW10_7 + 128'd1) >> 1;

  localparam logic [127:0] S5_C1_M   =
    ((128'd19130488174364327 << 49) / POW10_17 + 128'd1) >> 1;
  localparam logic [127:0] S5_C3_M   =
    ((128'd4596051850950526 << 49) / POW10_18 + 128'd1) >> 1;
  localparam logic [127:0] S5_C5_M   =
    ((128'd4223017442715702 << 49) / POW10_20 + 128'd1) >> 1;

  localparam logic [127:0] S7_C1_M   =
    ((128'd21689567455156572 << 49) / POW10_17 + 128'd1) >> 1;
  localparam logic [127:0] S7_C3_M   =
    ((128'd8194757398825834 << 49) / POW10_18 + 128'd1) >> 1;
  localparam logic [127:0] S7_C5_M   =
    ((128'd16593568955483007 << 49) / POW10_20 + 128'd1) >> 1;
  localparam logic [127:0] S7_C7_M   =
    ((128'd11965564496759948 << 49) / POW10_22 + 128'd1) >> 1;

  localparam logic [127:0] T5_C0_M   =
    ((128'd38260975296624476 << 49) / POW10_20 + 128'd1) >> 1;
  localparam logic [127:0] T5_C1_M   =
    ((128'd7652194684902834 << 49) / POW10_16 + 128'd1) >> 1;
  localparam logic [127:0] T5_C3_M   =
    ((128'd7353682621097166 << 49) / POW10_17 + 128'd1) >> 1;
  localparam logic [127:0] T5_C5_M   =
    ((128'd2702731463794033 << 49) / POW10_18 + 128'd1) >> 1;

  localparam logic [127:0] T7_C0_M   =
    ((128'd43379132689107155 << 49) / POW10_20 + 128'd1) >> 1;
  localparam logic [127:0] T7_C1_M   =
    ((128'd8675825874601593 << 49) / POW10_16 + 128'd1) >> 1;
  localparam logic [127:0] T7_C3_M   =
    ((128'd13111610042441557 << 49) / POW10_17 + 128'd1) >> 1;
  localparam logic [127:0] T7_C5_M   =
    ((128'd10619884719547454 << 49) / POW10_18 + 128'd1) >> 1;
  localparam logic [127:0] T7_C7_M   =
    ((128'd3063185603617004 << 49) / POW10_19 + 128'd1) >> 1;

  // Constant-term contribution: round(c0 * 2^24 / 2^48), all c0 are positive.
  localparam logic [127:0] HALF_Q24 = 128'd1 << (FRAC_W - 1);

  function automatic coef_t coef_of(row_e row);
    coef_t c;
    c = '0;
    unique case (row)
      ROW_SIG3: begin
        c.c1 = C_W'(S3_C1_M);
        c.c3 = -C_W'(S3_C3_M);
      end
      ROW_SIG5: begin
        c.c1 = C_W'(S5_C1_M);
        c.c3 = -C_W'(S5_C3_M);
        c.c5 = C_W'(S5_C5_M);
      end
      ROW_SIG7: begin
        c.c1 = C_W'(S7_C1_M);
        c.c3 = -C_W'(S7_C3_M);
        c.c5 = C_W'(S7_C5_M);
        c.c7 = -C_W'(S7_C7_M);
      end
      ROW_TANH5: begin
        c.c1 = C_W'(T5_C1_M);
        c.c3 = -C_W'(T5_C3_M);
        c.c5 = C_W'(T5_C5_M);
      end
      ROW_TANH7: begin
        c.c1 = C_W'(T7_C1_M);
        c.c3 = -C_W'(T7_C3_M);
        c.c5 = C_W'(T7_C5_M);
        c.c7 = -C_W'(T7_C7_M);
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [S_W-1:0] term0_of(row_e row);
    logic signed [S_W-1:0] t;
    unique case (row) inside
      ROW_SIG3, ROW_SIG5, ROW_SIG7: t = S_W'((SIG_C0_M + HALF_Q24) >> FRAC_W);
      ROW_TANH5:                    t = S_W'((T5_C0_M + HALF_Q24) >> FRAC_W);
      ROW_TANH7:                    t = S_W'((T7_C0_M + HALF_Q24) >> FRAC_W);
      default:                      t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== hw/rtl/polynomial_activation_unit_top.sv =====
// Polynomial sigmoid / tanh unit, Q8.24 in and out; uses pau_pkg, pau_powers, pau_poly.
// A beat passes the input register that takes start_i, four 4-stage multiply units for
// x^2..x^7, four parallel 4-stage coefficient multiplies and the sum register that drives done_o.
// Throughput: one beat per cycle; busy_o is always low and the result strobe cannot stall.
// Reset: asynchronous, active low; clears all valid bits and sets both orders to 7.
`timescale 1ns / 1ps

module polynomial_activation_unit_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command channel
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 kind_i,
  input  logic signed [pau_pkg::X_W-1:0]       x_value_i,
  input  logic                                 last_in_i,
  // result channel
  output logic                                 done_o,
  output logic signed [pau_pkg::Y_W-1:0]       y_value_o,
  output logic                                 last_out_o,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [pau_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [pau_pkg::ORD_W-1:0]            cfg_wdata_i
);
  import pau_pkg::*;

  logic                   accept;
  logic [ORD_W-1:0]       sig_order_q;
  logic [ORD_W-1:0]       tanh_order_q;
  row_e                   row_d;
  logic                   in_valid_q;
  logic signed [X_W-1:0]  in_x_q;
  meta_t                  in_meta_q;
  logic                   pow_vld;
  pow_beat_t              pow_beat;

  // Every stage advances each cycle, so a new beat is always welcome.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Order registers; writes to unknown indexes drop silently.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_order_q  <= ORDER_7;
      tanh_order_q <= ORDER_7;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIGMOID_ORDER: sig_order_q  <= cfg_wdata_i;
        CFG_TANH_ORDER:    tanh_order_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pick the coefficient row at the door; it rides along with the beat.
  always_comb begin
    if (kind_i == KIND_TANH) begin
      row_d = (tanh_order_q == ORDER_5) ? ROW_TANH5 : ROW_TANH7;
    end else begin
      unique case (sig_order_q)
        ORDER_3: row_d = ROW_SIG3;
        ORDER_5: row_d = ROW_SIG5;
        default: row_d = ROW_SIG7;
      endcase
    end
  end

  // Input register: holds the accepted beat for the first multiply.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    in_x_q    <= x_value_i;
    in_meta_q <= '{last: last_in_i, row: row_d};
  end

  // Odd powers of x, 16 stages.
  pau_powers u_powers (
    .clk_i, .rst_ni,
    .valid_i (in_valid_q),
    .x_i     (in_x_q),
    .meta_i  (in_meta_q),
    .valid_o (pow_vld),
    .beat_o  (pow_beat)
  );

  // Coefficient products, sum and output register, 5 stages.
  pau_poly u_poly (
    .clk_i, .rst_ni,
    .valid_i (pow_vld),
    .beat_i  (pow_beat),
    .valid_o (done_o),
    .y_o     (y_value_o),
    .last_o  (last_out_o)
  );

  // A result strobe only ever follows a beat taken the fixed latency earlier.
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_valid_q, PIPE_LAT))
    else $error("result strobe without a matching input beat");

  // The last-of-vector flag must stay with its own beat through every stage.
  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (last_out_o == $past(in_meta_q.last, PIPE_LAT)))
    else $error("last flag slipped against its beat");

  // With only one beat in flight per slot, an idle gap must show as an idle strobe.
  a_idle_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_valid_q, PIPE_LAT) |-> !done_o)
    else $error("result strobe during an idle slot");

endmodule

// ===== hw/rtl/pau_mul.sv =====
// Four-stage signed multiply with rounding right shift and symmetric saturation to 48 bits.
// Depends on pau_pkg for chunk width, result width and the saturation limit.
`timescale 1ns / 1ps

module pau_mul #(
  parameter int unsigned A_W    = 32,
  parameter int unsigned B_W    = 32,
  parameter int unsigned SHIFT  = 24,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [A_W-1:0]         a_i,
  input  logic signed [B_W-1:0]         b_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic signed [pau_pkg::P_W-1:0] p_o,
  output logic [SIDE_W-1:0]             side_o
);
  import pau_pkg::*;

  localparam int unsigned NA     = (A_W + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned NB     = (B_W + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned PAD_A  = NA * CHUNK_W;
  localparam int unsigned PAD_B  = NB * CHUNK_W;
  localparam int unsigned PROD_W = PAD_A + PAD_B;
  localparam int unsigned NPP    = NA * NB;

  localparam logic [PROD_W-1:0] RND   = PROD_W'(1) << (SHIFT - 1);
  localparam logic [PROD_W-1:0] LIM_W = PROD_W'(P_LIM);

  logic [A_W-1:0]          a_mag;
  logic [B_W-1:0]          b_mag;
  logic [MUL_LAT-1:0]      vld_q;
  logic [PAD_A-1:0]        ma_q;
  logic [PAD_B-1:0]        mb_q;
  logic                    neg_q [3];
  logic [SIDE_W-1:0]       side_q [MUL_LAT];
  logic [2*CHUNK_W-1:0]    pp_q [NPP];
  logic [PROD_W-1:0]       acc_d, acc_q;
  logic [PROD_W-1:0]       quo_w;
  logic [P_W-1:0]          mag_w;
  logic signed [P_W-1:0]   p_d, p_q;

  // Stage 1: split sign and magnitude.
  assign a_mag = a_i[A_W-1] ? (~a_i + 1'b1) : a_i;
  assign b_mag = b_i[B_W-1] ? (~b_i + 1'b1) : b_i;

  // Stage 3: weight the partial products and add the rounding half.
  always_comb begin
    acc_d = RND;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc_d = acc_d + (PROD_W'(pp_q[i*NB+j]) << ((i + j) * CHUNK_W));
      end
    end
  end

  // Stage 4: drop fraction bits, clip, restore sign.
  always_comb begin
    quo_w = acc_q >> SHIFT;
    mag_w = (quo_w > LIM_W) ? P_LIM : quo_w[P_W-1:0];
    p_d   = neg_q[2] ? (~mag_w + 1'b1) : mag_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[MUL_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q      <= PAD_A'(a_mag);
    mb_q      <= PAD_B'(b_mag);
    neg_q[0]  <= a_i[A_W-1] ^ b_i[B_W-1];
    side_q[0] <= side_i;

    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i*NB+j] <= ma_q[i*CHUNK_W +: CHUNK_W] * mb_q[j*CHUNK_W +: CHUNK_W];
      end
    end
    neg_q[1]  <= neg_q[0];
    side_q[1] <= side_q[0];

    acc_q     <= acc_d;
    neg_q[2]  <= neg_q[1];
    side_q[2] <= side_q[1];

    p_q       <= p_d;
    side_q[3] <= side_q[2];
  end

  assign valid_o = vld_q[MUL_LAT-1];
  assign p_o     = p_q;
  assign side_o  = side_q[MUL_LAT-1];

endmodule

// ===== hw/rtl/pau_powers.sv =====
// Chain of four multiply units forming x^2, x^3, x^5 and x^7 in Q.24.
// Depends on pau_pkg and pau_mul.
`timescale 1ns / 1ps

module pau_powers (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [pau_pkg::X_W-1:0] x_i,
  input  pau_pkg::meta_t                 meta_i,
  output logic                           valid_o,
  output pau_pkg::pow_beat_t             beat_o
);
  import pau_pkg::*;

  typedef struct packed {
    meta_t                 meta;
    logic signed [X_W-1:0] x;
  } sq_side_t;

  typedef struct packed {
    meta_t                 meta;
    logic signed [X_W-1:0] x;
    logic signed [P_W-1:0] u;
  } p3_side_t;

  typedef struct packed {
    meta_t                 meta;
    logic signed [X_W-1:0] x;
    logic signed [P_W-1:0] u;
    logic signed [P_W-1:0] p3;
  } p5_side_t;

  typedef struct packed {
    meta_t                 meta;
    logic signed [X_W-1:0] x;
    logic signed [P_W-1:0] p3;
    logic signed [P_W-1:0] p5;
  } p7_side_t;

  localparam int unsigned SQ_SW = $bits(sq_side_t);
  localparam int unsigned P3_SW = $bits(p3_side_t);
  localparam int unsigned P5_SW = $bits(p5_side_t);
  localparam int unsigned P7_SW = $bits(p7_side_t);

  sq_side_t               sq_in, sq_out;
  p3_side_t               p3_in, p3_out;
  p5_side_t               p5_in, p5_out;
  p7_side_t               p7_in, p7_out;
  logic [SQ_SW-1:0]       sq_side_w;
  logic [P3_SW-1:0]       p3_side_w;
  logic [P5_SW-1:0]       p5_side_w;
  logic [P7_SW-1:0]       p7_side_w;
  logic                   sq_vld, p3_vld, p5_vld;
  logic signed [P_W-1:0]  u_w, p3_w, p5_w, p7_w;

  assign sq_in = '{meta: meta_i, x: x_i};

  pau_mul #(.A_W(X_W), .B_W(X_W), .SHIFT(FRAC_W), .SIDE_W(SQ_SW)) u_sq (
    .clk_i, .rst_ni,
    .valid_i (valid_i),
    .a_i     (x_i),
    .b_i     (x_i),
    .side_i  (sq_in),
    .valid_o (sq_vld),
    .p_o     (u_w),
    .side_o  (sq_side_w)
  );
  assign sq_out = sq_side_t'(sq_side_w);
  assign p3_in  = '{meta: sq_out.meta, x: sq_out.x, u: u_w};

  pau_mul #(.A_W(P_W), .B_W(X_W), .SHIFT(FRAC_W), .SIDE_W(P3_SW)) u_p3 (
    .clk_i, .rst_ni,
    .valid_i (sq_vld),
    .a_i     (u_w),
    .b_i     (sq_out.x),
    .side_i  (p3_in),
    .valid_o (p3_vld),
    .p_o     (p3_w),
    .side_o  (p3_side_w)
  );
  assign p3_out = p3_side_t'(p3_side_w);
  assign p5_in  = '{meta: p3_out.meta, x: p3_out.x, u: p3_out.u, p3: p3_w};

  pau_mul #(.A_W(P_W), .B_W(P_W), .SHIFT(FRAC_W), .SIDE_W(P5_SW)) u_p5 (
    .clk_i, .rst_ni,
    .valid_i (p3_vld),
    .a_i     (p3_w),
    .b_i     (p3_out.u),
    .side_i  (p5_in),
    .valid_o (p5_vld),
    .p_o     (p5_w),
    .side_o  (p5_side_w)
  );
  assign p5_out = p5_side_t'(p5_side_w);
  assign p7_in  = '{meta: p5_out.meta, x: p5_out.x, p3: p5_out.p3, p5: p5_w};

  pau_mul #(.A_W(P_W), .B_W(P_W), .SHIFT(FRAC_W), .SIDE_W(P7_SW)) u_p7 (
    .clk_i, .rst_ni,
    .valid_i (p5_vld),
    .a_i     (p5_w),
    .b_i     (p5_out.u),
    .side_i  (p7_in),
    .valid_o (valid_o),
    .p_o     (p7_w),
    .side_o  (p7_side_w)
  );
  assign p7_out = p7_side_t'(p7_side_w);

  assign beat_o = '{meta: p7_out.meta, x: p7_out.x, p3: p7_out.p3,
                    p5: p7_out.p5, p7: p7_w};

endmodule

// ===== hw/rtl/pau_poly.sv =====
// Coefficient multiplies, five-term sum and Q8.24 saturation for one beat per cycle.
// Depends on pau_pkg (coefficient tables) and pau_mul.
`timescale 1ns / 1ps

module pau_poly (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  pau_pkg::pow_beat_t             beat_i,
  output logic                           valid_o,
  output logic signed [pau_pkg::Y_W-1:0] y_o,
  output logic                           last_o
);
  import pau_pkg::*;

  localparam int unsigned META_W = $bits(meta_t);

  coef_t                  cf;
  logic                   t_vld;
  logic [META_W-1:0]      meta_w;
  meta_t                  t_meta;
  logic signed [P_W-1:0]  t1, t3, t5, t7;
  logic signed [S_W-1:0]  sum_w;
  logic signed [Y_W-1:0]  y_d;
  logic                   vld_q;
  logic signed [Y_W-1:0]  y_q;
  logic                   last_q;

  assign cf = coef_of(beat_i.meta.row);

  pau_mul #(.A_W(C_W), .B_W(X_W), .SHIFT(CF_FRAC_W), .SIDE_W(META_W)) u_t1 (
    .clk_i, .rst_ni,
    .valid_i (valid_i),
    .a_i     (cf.c1),
    .b_i     (beat_i.x),
    .side_i  (beat_i.meta),
    .valid_o (t_vld),
    .p_o     (t1),
    .side_o  (meta_w)
  );

  pau_mul #(.A_W(C_W), .B_W(P_W), .SHIFT(CF_FRAC_W), .SIDE_W(1)) u_t3 (
    .clk_i, .rst_ni,
    .valid_i (valid_i),
    .a_i     (cf.c3),
    .b_i     (beat_i.p3),
    .side_i  (1'b0),
    .valid_o (),
    .p_o     (t3),
    .side_o  ()
  );

  pau_mul #(.A_W(C_W), .B_W(P_W), .SHIFT(CF_FRAC_W), .SIDE_W(1)) u_t5 (
    .clk_i, .rst_ni,
    .valid_i (valid_i),
    .a_i     (cf.c5),
    .b_i     (beat_i.p5),
    .side_i  (1'b0),
    .valid_o (),
    .p_o     (t5),
    .side_o  ()
  );

  pau_mul #(.A_W(C_W), .B_W(P_W), .SHIFT(CF_FRAC_W), .SIDE_W(1)) u_t7 (
    .clk_i, .rst_ni,
    .valid_i (valid_i),
    .a_i     (cf.c7),
    .b_i     (beat_i.p7),
    .side_i  (1'b0),
    .valid_o (),
    .p_o     (t7),
    .side_o  ()
  );

  assign t_meta = meta_t'(meta_w);

  // Sum the terms, then clip to the Q8.24 range when the upper bits disagree.
  always_comb begin
    sum_w = term0_of(t_meta.row) + S_W'(t1) + S_W'(t3) + S_W'(t5) + S_W'(t7);
    if (sum_w[S_W-1:Y_W-1] == '0 || sum_w[S_W-1:Y_W-1] == '1) begin
      y_d = sum_w[Y_W-1:0];
    end else if (sum_w[S_W-1]) begin
      y_d = {1'b1, {(Y_W-1){1'b0}}};
    end else begin
      y_d = {1'b0, {(Y_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= t_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    last_q <= t_meta.last;
  end

  assign valid_o = vld_q;
  assign y_o     = y_q;
  assign last_o  = last_q;

endmodule
